// ----- hw/rtl/tbpb_pkg.sv -----
// ----------------------------------------------------------------------------
// Tournament branch predictor with target buffer: shared definitions
// Transaction payload types, register map codes and the 2-bit counter update.
// ----------------------------------------------------------------------------
package tbpb_pkg;

    localparam int TARGET_BITS = 32;
    localparam int PC_BITS     = 32;
    localparam int CFG_BITS    = 4;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    localparam logic [1:0] REG_BIMODAL_INDEX_BITS = 2'd0;
    localparam logic [1:0] REG_HISTORY_BITS       = 2'd1;
    localparam logic [1:0] REG_BTB_INDEX_BITS     = 2'd2;

    localparam logic [CFG_BITS-1:0] RST_BIMODAL_INDEX_BITS = 4'd11;
    localparam logic [CFG_BITS-1:0] RST_HISTORY_BITS       = 4'd11;
    localparam logic [CFG_BITS-1:0] RST_BTB_INDEX_BITS     = 4'd9;

    localparam logic [1:0] CTR_STRONG_TAKEN  = 2'd3;
    localparam logic [1:0] CTR_PREFER_GSHARE = 2'd0;

    typedef struct packed {
        logic [PC_BITS-1:0]     pc;
        logic                   taken;
        logic [TARGET_BITS-1:0] target;
    } item_t;

    typedef struct packed {
        logic                   one_bit_correct;
        logic                   two_bit_correct;
        logic                   gshare_correct;
        logic                   tournament_correct;
        logic                   chose_bimodal;
        logic                   btb_attempted;
        logic                   btb_correct;
        logic [TARGET_BITS-1:0] predicted_target;
    } result_t;

    function automatic logic [1:0] train2(input logic [1:0] c, input logic t);
        logic [1:0] n;
        begin
            n = c;
            if (t)
            begin
                if (c != 2'd3)
                    n = c + 2'd1;
            end
            else
            begin
                if (c != 2'd0)
                    n = c - 2'd1;
            end
            return n;
        end
    endfunction

endpackage

// ----- hw/rtl/tournament_branch_predictor_btb.sv -----
// ----------------------------------------------------------------------------
// Tournament branch predictor with branch target buffer
// Scores a 1-bit bimodal predictor guarding a target buffer, a 2-bit bimodal
// predictor, a gshare predictor and a tournament chooser on each resolved
// branch, then trains them; the chooser only when the two counters disagree.
// ----------------------------------------------------------------------------
// Usage:
// Each item transaction carries one resolved branch (pc, taken, target) and
// produces exactly one result transaction reporting how each predictor did.
// Both channels use valid and stall; a transaction completes on a rising edge
// with valid high and stall low.
// The tables are read in the cycle an item is accepted and written back when
// the table stage passes the item on, which also loads the result register.
// One item per cycle is sustained while the receiver does not stall; the
// rate is set by the single read and single write port of each table memory,
// and the newest write is forwarded so that consecutive branches to one entry
// agree. After reset all 2**PC_INDEX_BITS entries (2048 by default) are
// cleared one per cycle while item_stall is high. While the receiver stalls,
// the result register holds; one further item is accepted into the table
// stage, and after that item_stall is raised. Configuration registers are
// written through APB only while idle, which the user ensures, not the block.
// ----------------------------------------------------------------------------
module tournament_branch_predictor_btb #(
    parameter int PC_INDEX_BITS = 11
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  tbpb_pkg::item_t                      item,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output tbpb_pkg::result_t                    result,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [tbpb_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [tbpb_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [tbpb_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);

    import tbpb_pkg::*;

    localparam int IW    = PC_INDEX_BITS;
    localparam int BTB_W = TARGET_BITS + 1;

    logic [CFG_BITS-1:0] bimodal_bits_reg;
    logic [CFG_BITS-1:0] history_bits_reg;
    logic [CFG_BITS-1:0] btb_bits_reg;

    logic          clearing_reg;
    logic [IW-1:0] clr_cnt_reg;

    logic [IW-1:0] hist_reg;
    logic [IW-1:0] hist_next;

    logic                   b_valid_reg;
    logic                   b_taken_reg;
    logic [TARGET_BITS-1:0] b_target_reg;
    logic [IW-1:0]          b_i1_reg;
    logic [IW-1:0]          b_i2_reg;
    logic [IW-1:0]          b_ig_reg;
    logic [IW-1:0]          b_ic_reg;

    logic    result_valid_reg;
    result_t result_reg;
    result_t result_next;

    logic          accept;
    logic          b_go;
    logic          cfg_write;
    logic [IW-1:0] pc_idx;
    logic [IW-1:0] i1;
    logic [IW-1:0] i2;
    logic [IW-1:0] ig;

    logic [BTB_W-1:0] btb_rd;
    logic [1:0]       two_rd;
    logic [1:0]       gsh_rd;
    logic [1:0]       cho_rd;

    logic [BTB_W-1:0] btb_wr;
    logic [1:0]       two_wr;
    logic [1:0]       gsh_wr;
    logic [1:0]       cho_wr;
    logic             cho_upd;
    logic             cho_wr_en;

    logic [IW-1:0] btb_wa;
    logic [IW-1:0] two_wa;
    logic [IW-1:0] gsh_wa;
    logic [IW-1:0] cho_wa;

    logic p1;
    logic pb;
    logic pg;
    logic use_bi;
    logic chosen_ok;
    logic toward_bi;
    logic [TARGET_BITS-1:0] stored;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bimodal_bits_reg <= RST_BIMODAL_INDEX_BITS;
            history_bits_reg <= RST_HISTORY_BITS;
            btb_bits_reg     <= RST_BTB_INDEX_BITS;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_BIMODAL_INDEX_BITS: bimodal_bits_reg <= pwdata[CFG_BITS-1:0];
                REG_HISTORY_BITS:       history_bits_reg <= pwdata[CFG_BITS-1:0];
                REG_BTB_INDEX_BITS:     btb_bits_reg     <= pwdata[CFG_BITS-1:0];
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_BIMODAL_INDEX_BITS: prdata = {{(APB_DATA_W-CFG_BITS){1'b0}}, bimodal_bits_reg};
            REG_HISTORY_BITS:       prdata = {{(APB_DATA_W-CFG_BITS){1'b0}}, history_bits_reg};
            REG_BTB_INDEX_BITS:     prdata = {{(APB_DATA_W-CFG_BITS){1'b0}}, btb_bits_reg};
            default:                prdata = '0;
        endcase
    end

    // Handshake
    assign b_go       = b_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall = clearing_reg || (b_valid_reg && !b_go);
    assign accept     = item_valid && !item_stall;

    // Index generation
    assign pc_idx    = item.pc[IW-1:0];
    assign i1        = pc_idx & ~({IW{1'b1}} << btb_bits_reg);
    assign i2        = pc_idx & ~({IW{1'b1}} << bimodal_bits_reg);
    assign ig        = pc_idx ^ (hist_reg & ~({IW{1'b1}} << history_bits_reg));
    assign hist_next = {hist_reg[IW-2:0], item.taken};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= '0;
        end
        else if (accept)
        begin
            hist_reg <= hist_next;
        end
    end

    // Clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == {IW{1'b1}})
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // Table stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            b_valid_reg <= 1'b1;
        end
        else if (b_go)
        begin
            b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_taken_reg  <= item.taken;
            b_target_reg <= item.target;
            b_i1_reg     <= i1;
            b_i2_reg     <= i2;
            b_ig_reg     <= ig;
            b_ic_reg     <= pc_idx;
        end
    end

    assign p1        = btb_rd[0];
    assign stored    = btb_rd[BTB_W-1:1];
    assign pb        = two_rd[1];
    assign pg        = gsh_rd[1];
    assign use_bi    = cho_rd[1];
    assign chosen_ok = (use_bi ? pb : pg) == b_taken_reg;
    assign toward_bi = use_bi ? chosen_ok : !chosen_ok;
    assign cho_upd   = pb != pg;

    always_comb
    begin
        result_next.one_bit_correct    = p1 == b_taken_reg;
        result_next.two_bit_correct    = pb == b_taken_reg;
        result_next.gshare_correct     = pg == b_taken_reg;
        result_next.tournament_correct = chosen_ok;
        result_next.chose_bimodal      = use_bi;
        result_next.btb_attempted      = p1;
        result_next.btb_correct        = p1 && (stored == b_target_reg);
        result_next.predicted_target   = stored;
    end

    // Write-back, or the clearing pass
    always_comb
    begin
        if (clearing_reg)
        begin
            btb_wa    = clr_cnt_reg;
            two_wa    = clr_cnt_reg;
            gsh_wa    = clr_cnt_reg;
            cho_wa    = clr_cnt_reg;
            btb_wr    = {{TARGET_BITS{1'b0}}, 1'b1};
            two_wr    = CTR_STRONG_TAKEN;
            gsh_wr    = CTR_STRONG_TAKEN;
            cho_wr    = CTR_PREFER_GSHARE;
            cho_wr_en = 1'b1;
        end
        else
        begin
            btb_wa    = b_i1_reg;
            two_wa    = b_i2_reg;
            gsh_wa    = b_ig_reg;
            cho_wa    = b_ic_reg;
            btb_wr    = {b_taken_reg ? b_target_reg : stored, b_taken_reg};
            two_wr    = train2(two_rd, b_taken_reg);
            gsh_wr    = train2(gsh_rd, b_taken_reg);
            cho_wr    = train2(cho_rd, toward_bi);
            cho_wr_en = b_go && cho_upd;
        end
    end

    tbpb_table #(.ADDR_BITS(IW), .DATA_BITS(BTB_W)) u_btb (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (i1),
        .rd_data (btb_rd),
        .wr_en   (clearing_reg || b_go),
        .wr_addr (btb_wa),
        .wr_data (btb_wr)
    );

    tbpb_table #(.ADDR_BITS(IW), .DATA_BITS(2)) u_two_bit (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (i2),
        .rd_data (two_rd),
        .wr_en   (clearing_reg || b_go),
        .wr_addr (two_wa),
        .wr_data (two_wr)
    );

    tbpb_table #(.ADDR_BITS(IW), .DATA_BITS(2)) u_gshare (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (ig),
        .rd_data (gsh_rd),
        .wr_en   (clearing_reg || b_go),
        .wr_addr (gsh_wa),
        .wr_data (gsh_wr)
    );

    tbpb_table #(.ADDR_BITS(IW), .DATA_BITS(2)) u_chooser (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (pc_idx),
        .rd_data (cho_rd),
        .wr_en   (cho_wr_en),
        .wr_addr (cho_wa),
        .wr_data (cho_wr)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (b_go)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_go)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Checks
    a_no_item_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> item_stall)
        else $error("Item accepted during the clearing pass.");

    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> b_valid_reg)
        else $error("Accepted transaction did not reach the table stage.");

    a_stage_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && result_valid_reg && result_stall) |=> b_valid_reg && $stable(b_i1_reg))
        else $error("Table stage lost a transaction while the result was stalled.");

    a_history_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(hist_reg))
        else $error("Global history moved without a transaction.");

    a_clearing_quiet_stage: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !b_valid_reg && !result_valid_reg)
        else $error("Pipeline busy during the clearing pass.");

endmodule

// ----- hw/rtl/tbpb_table.sv -----
// ----------------------------------------------------------------------------
// Predictor table
// Synchronous memory with a registered read port and forwarding of the most
// recent write, so that a read issued alongside a write to the same entry
// still returns the newest value.
// ----------------------------------------------------------------------------
module tbpb_table #(
    parameter int ADDR_BITS = 11,
    parameter int DATA_BITS = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [DATA_BITS-1:0] rd_data,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] q_reg;
    logic [ADDR_BITS-1:0] rd_addr_reg;
    logic                 fwd_valid_reg;
    logic [ADDR_BITS-1:0] fwd_addr_reg;
    logic [DATA_BITS-1:0] fwd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg       <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
        if (wr_en)
        begin
            fwd_addr_reg <= wr_addr;
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            fwd_valid_reg <= 1'b1;
        end
    end

    assign rd_data = (fwd_valid_reg && (fwd_addr_reg == rd_addr_reg)) ? fwd_data_reg : q_reg;

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tournament branch predictor with target buffer: self-checking testbench
// Resolved branches are sent through the item channel and every result
// transaction is compared field by field with a behavioural predictor that
// keeps its own copy of the tables, the global history and the index widths.
// Index and history widths are changed between phases over the APB port,
// including values below and above the usable range, and both channels
// idle at random.
// ----------------------------------------------------------------------------
module tb_top;

    import tbpb_pkg::*;

    localparam int IDX_BITS    = 11;
    localparam int DEPTH       = 1 << IDX_BITS;
    localparam int HOT_COUNT   = 16;
    localparam int QUIET_LIMIT = 10000;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 265;
    localparam int MAX_REPORTS = 100;

    typedef enum int {ALWAYS_TAKEN, NEVER_TAKEN, ALTERNATING, LOOP_EXIT, COIN_FLIP}
        branch_kind_t;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  item_valid   = 1'b0;
    logic                  item_stall;
    item_t                 item         = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    result_t               result;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [APB_ADDR_W-1:0] paddr        = '0;
    logic [APB_DATA_W-1:0] pwdata       = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    logic                   one_bit_tbl [DEPTH];
    logic [1:0]             two_bit_tbl [DEPTH];
    logic [1:0]             gshare_tbl  [DEPTH];
    logic [1:0]             chooser_tbl [DEPTH];
    logic [TARGET_BITS-1:0] target_tbl  [DEPTH];
    logic [IDX_BITS-1:0]    branch_history;
    logic [CFG_BITS-1:0]    bimodal_bits;
    logic [CFG_BITS-1:0]    history_len;
    logic [CFG_BITS-1:0]    btb_bits;

    logic [PC_BITS-1:0]     hot_pc     [HOT_COUNT];
    logic [TARGET_BITS-1:0] hot_target [HOT_COUNT];
    branch_kind_t           hot_kind   [HOT_COUNT];
    int unsigned            hot_count  [HOT_COUNT];

    logic [CFG_BITS-1:0] phase_settings [PHASES][3] = '{
        '{4'd4,  4'd3,  4'd4},
        '{4'd11, 4'd11, 4'd11},
        '{4'd15, 4'd15, 4'd15},
        '{4'd0,  4'd0,  4'd0},
        '{4'd6,  4'd9,  4'd13},
        '{4'd1,  4'd2,  4'd8}
    };

    item_t   branch_queue [$];
    result_t outcome_queue [$];
    logic    steady      = 1'b0;
    int      mismatches  = 0;
    int      results_seen = 0;
    int      target_hits = 0;
    int      bimodal_picks = 0;
    int      quiet_cycles = 0;

    tournament_branch_predictor_btb i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #6 clk = ~clk;

    task automatic log_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
    endtask

    function automatic logic [IDX_BITS-1:0] low_bits_mask(input logic [CFG_BITS-1:0] n);
        int w;
        w = (n > IDX_BITS) ? IDX_BITS : int'(n);
        return IDX_BITS'((1 << w) - 1);
    endfunction

    function automatic logic [1:0] bump_counter(input logic [1:0] c, input logic up);
        if (up)
            return (c == 2'd3) ? c : c + 2'd1;
        return (c == 2'd0) ? c : c - 2'd1;
    endfunction

    function automatic void clear_predictor();
        for (int i = 0; i < DEPTH; i++)
        begin
            one_bit_tbl[i] = 1'b1;
            two_bit_tbl[i] = CTR_STRONG_TAKEN;
            gshare_tbl[i]  = CTR_STRONG_TAKEN;
            chooser_tbl[i] = CTR_PREFER_GSHARE;
            target_tbl[i]  = '0;
        end
        branch_history = '0;
        bimodal_bits   = RST_BIMODAL_INDEX_BITS;
        history_len    = RST_HISTORY_BITS;
        btb_bits       = RST_BTB_INDEX_BITS;
    endfunction

    // Scores one resolved branch against the current tables, then trains them.
    function automatic result_t predict_branch(input item_t br);
        logic [IDX_BITS-1:0] pc_idx;
        logic [IDX_BITS-1:0] i1;
        logic [IDX_BITS-1:0] i2;
        logic [IDX_BITS-1:0] ig;
        logic                p1;
        logic                pb;
        logic                pg;
        logic                use_bi;
        logic                chosen_ok;
        logic [1:0]          ch;
        result_t             r;
        pc_idx    = br.pc[IDX_BITS-1:0];
        i1        = pc_idx & low_bits_mask(btb_bits);
        i2        = pc_idx & low_bits_mask(bimodal_bits);
        ig        = pc_idx ^ (branch_history & low_bits_mask(history_len));
        p1        = one_bit_tbl[i1];
        pb        = two_bit_tbl[i2][1];
        pg        = gshare_tbl[ig][1];
        ch        = chooser_tbl[pc_idx];
        use_bi    = ch[1];
        chosen_ok = ((use_bi ? pb : pg) == br.taken);

        r.one_bit_correct    = (p1 == br.taken);
        r.two_bit_correct    = (pb == br.taken);
        r.gshare_correct     = (pg == br.taken);
        r.tournament_correct = chosen_ok;
        r.chose_bimodal      = use_bi;
        r.btb_attempted      = p1;
        r.btb_correct        = p1 && (target_tbl[i1] == br.target);
        r.predicted_target   = target_tbl[i1];

        one_bit_tbl[i1] = br.taken;
        two_bit_tbl[i2] = bump_counter(two_bit_tbl[i2], br.taken);
        gshare_tbl[ig]  = bump_counter(gshare_tbl[ig], br.taken);
        if (br.taken)
            target_tbl[i1] = br.target;
        branch_history = {branch_history[IDX_BITS-2:0], br.taken};
        if (pb != pg)
            chooser_tbl[pc_idx] = bump_counter(ch, use_bi ? chosen_ok : !chosen_ok);
        return r;
    endfunction

    task automatic compare_outcome(input result_t got, input result_t want);
        if (got.one_bit_correct !== want.one_bit_correct)
            log_mismatch("one_bit_correct", 64'(got.one_bit_correct),
                         64'(want.one_bit_correct));
        if (got.two_bit_correct !== want.two_bit_correct)
            log_mismatch("two_bit_correct", 64'(got.two_bit_correct),
                         64'(want.two_bit_correct));
        if (got.gshare_correct !== want.gshare_correct)
            log_mismatch("gshare_correct", 64'(got.gshare_correct),
                         64'(want.gshare_correct));
        if (got.tournament_correct !== want.tournament_correct)
            log_mismatch("tournament_correct", 64'(got.tournament_correct),
                         64'(want.tournament_correct));
        if (got.chose_bimodal !== want.chose_bimodal)
            log_mismatch("chose_bimodal", 64'(got.chose_bimodal),
                         64'(want.chose_bimodal));
        if (got.btb_attempted !== want.btb_attempted)
            log_mismatch("btb_attempted", 64'(got.btb_attempted),
                         64'(want.btb_attempted));
        if (got.btb_correct !== want.btb_correct)
            log_mismatch("btb_correct", 64'(got.btb_correct), 64'(want.btb_correct));
        if (got.predicted_target !== want.predicted_target)
            log_mismatch("predicted_target", 64'(got.predicted_target),
                         64'(want.predicted_target));
    endtask

    task automatic apb_access(input logic [1:0] idx, input logic wr,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_register(input logic [1:0] idx, input logic [CFG_BITS-1:0] want);
        logic [APB_DATA_W-1:0] rdata;
        apb_access(idx, 1'b0, '0, rdata);
        if (rdata[CFG_BITS-1:0] !== want)
            log_mismatch("register read back", 64'(rdata[CFG_BITS-1:0]), 64'(want));
    endtask

    task automatic set_register(input logic [1:0] idx, input logic [CFG_BITS-1:0] value);
        logic [APB_DATA_W-1:0] rdata;
        apb_access(idx, 1'b1, APB_DATA_W'(value), rdata);
        case (idx)
            REG_BIMODAL_INDEX_BITS: bimodal_bits = value;
            REG_HISTORY_BITS:       history_len  = value;
            REG_BTB_INDEX_BITS:     btb_bits     = value;
            default: ;
        endcase
        check_register(idx, value);
    endtask

    function automatic void shuffle_hot_branches();
        for (int k = 0; k < HOT_COUNT; k++)
        begin
            hot_pc[k]     = $urandom;
            hot_target[k] = $urandom;
            hot_kind[k]   = branch_kind_t'($urandom_range(COIN_FLIP));
            hot_count[k]  = 0;
        end
    endfunction

    // Mostly recurring branches with characteristic outcome patterns, so that
    // the counters, the chooser and the target buffer all get trained.
    function automatic item_t random_branch();
        int    k;
        item_t br;
        if ($urandom_range(99) < 20)
        begin
            br.pc     = $urandom;
            br.taken  = 1'($urandom_range(1));
            br.target = $urandom;
            return br;
        end
        k     = $urandom_range(HOT_COUNT - 1);
        br.pc = hot_pc[k];
        if ($urandom_range(3) == 0)
            br.pc[PC_BITS-1:IDX_BITS] = (PC_BITS - IDX_BITS)'($urandom);
        case (hot_kind[k])
            ALWAYS_TAKEN: br.taken = 1'b1;
            NEVER_TAKEN:  br.taken = 1'b0;
            ALTERNATING:  br.taken = hot_count[k][0];
            LOOP_EXIT:    br.taken = (hot_count[k] % 5) != 4;
            default:      br.taken = 1'($urandom_range(1));
        endcase
        hot_count[k]++;
        br.target = ($urandom_range(9) == 0) ? TARGET_BITS'($urandom) : hot_target[k];
        return br;
    endfunction

    function automatic item_t make_branch(input logic [PC_BITS-1:0] pc, input logic taken,
                                          input logic [TARGET_BITS-1:0] target);
        item_t br;
        br.pc     = pc;
        br.taken  = taken;
        br.target = target;
        return br;
    endfunction

    task automatic wait_drained();
        do
            @(posedge clk);
        while (branch_queue.size() != 0 || item_valid || outcome_queue.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else
        begin
            if (item_valid && !item_stall)
                outcome_queue.push_back(predict_branch(item));
            if (!item_valid || !item_stall)
            begin
                if (branch_queue.size() != 0 && (steady || $urandom_range(99) >= 33))
                begin
                    item       <= branch_queue.pop_front();
                    item_valid <= 1'b1;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                results_seen++;
                if (outcome_queue.size() == 0)
                begin
                    log_mismatch("result with no pending transaction", 64'(result), '0);
                end
                else
                begin
                    compare_outcome(result, outcome_queue[0]);
                    void'(outcome_queue.pop_front());
                end
                if (result.btb_correct)
                    target_hits++;
                if (result.chose_bimodal)
                    bimodal_picks++;
            end
            result_stall <= steady ? 1'b0 : ($urandom_range(99) < 33);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Timeout after %0d cycles without a transaction", quiet_cycles);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial
    begin
        clear_predictor();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);

        check_register(REG_BIMODAL_INDEX_BITS, RST_BIMODAL_INDEX_BITS);
        check_register(REG_HISTORY_BITS, RST_HISTORY_BITS);
        check_register(REG_BTB_INDEX_BITS, RST_BTB_INDEX_BITS);

        // Target buffer hit on a cleared entry, a wrong target, then a hit.
        branch_queue.push_back(make_branch('0, 1'b1, '0));
        branch_queue.push_back(make_branch('0, 1'b1, '1));
        branch_queue.push_back(make_branch('0, 1'b1, '1));
        // Not taken clears the 1-bit entry, so the buffer is no longer consulted.
        branch_queue.push_back(make_branch('1, 1'b0, '1));
        branch_queue.push_back(make_branch('1, 1'b0, '1));
        branch_queue.push_back(make_branch('1, 1'b1, '0));
        // A repeating pattern on branches that share one table index drives the components apart.
        for (int j = 0; j < 14; j++)
            branch_queue.push_back(make_branch({j[20:0], 11'h123}, (j % 3) == 2,
                                               32'hA5A5_0000 + j));
        shuffle_hot_branches();
        for (int j = 0; j < PHASE_ITEMS; j++)
            branch_queue.push_back(random_branch());
        wait_drained();

        for (int p = 0; p < PHASES; p++)
        begin
            set_register(REG_BIMODAL_INDEX_BITS, phase_settings[p][0]);
            set_register(REG_HISTORY_BITS, phase_settings[p][1]);
            set_register(REG_BTB_INDEX_BITS, phase_settings[p][2]);
            shuffle_hot_branches();
            steady = (p == 1);
            for (int j = 0; j < PHASE_ITEMS; j++)
                branch_queue.push_back(random_branch());
            wait_drained();
            steady = 1'b0;
        end

        if (outcome_queue.size() != 0)
            log_mismatch("results never delivered", 64'(outcome_queue.size()), '0);
        $display("Checked %0d branch results over %0d index and history settings.",
                 results_seen, PHASES + 1);
        $display("Target buffer hits: %0d, bimodal choices: %0d.", target_hits,
                 bimodal_picks);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
